FILE: sv/iira_pkg.sv
// Package for the indexed insert/remove array core.
// Holds opcode, status and cell command types plus default sizes; no dependencies.
package iira_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Internal compare width, covers positions and counts up to the largest capacity
    localparam int MAX_POS_W = 13;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    // Broadcast to every cell
    typedef struct packed {
        cmd_t                 cmd;
        logic [MAX_POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

FILE: sv/iira_cell.sv
// One storage cell of the array chain: holds an entry, shifts from a neighbour.
// Depends on iira_pkg.
module iira_cell #(
    parameter int DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                   clk,
    input  iira_pkg::cell_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0]  wr_data,
    input  logic [DATA_WIDTH-1:0]  left_data,   // entry below
    input  logic [DATA_WIDTH-1:0]  right_data,  // entry above
    output logic [DATA_WIDTH-1:0]  data,
    output logic [DATA_WIDTH-1:0]  sel_data     // entry if addressed, else zero
);

    localparam logic [iira_pkg::MAX_POS_W-1:0] IDX = iira_pkg::MAX_POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;
    logic                  above;

    assign hit   = (ctrl.pos == IDX);
    assign above = (IDX > ctrl.pos);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            iira_pkg::CMD_WRITE:
            begin
                if (hit)
                    data_next = wr_data;
            end
            iira_pkg::CMD_INSERT:
            begin
                if (above)
                    data_next = left_data;
                else if (hit)
                    data_next = wr_data;
            end
            iira_pkg::CMD_REMOVE:
            begin
                if (above || hit)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = hit ? data_reg : '0;

endmodule

FILE: sv/indexed_insert_remove_array_core.sv
// Top level of the indexed insert/remove array: cell chain, control and read path.
// Depends on iira_pkg and iira_cell.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  req     | in        | req_valid / req_ready | op, position, value
//  rsp     | out       | rsp_valid / rsp_ready | read_value, status, count, is_empty
//
// Each request beat produces one response beat, registered in stage 1 and then stage 2.
// The chain of cells updates at the accepting edge (all cells shift in parallel),
// so the sustained rate is one beat per cycle while responses are taken; the
// read path is registered as group OR (stage 1), then final OR (stage 2).
// Reset clears the entry count and both pipeline valids; cell contents are
// undefined until written. A stalled response holds the pipeline and req_ready
// drops once both stages are full.
module indexed_insert_remove_array_core #(
    parameter int CAPACITY   = iira_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [iira_pkg::OP_W-1:0]     op,
    input  logic [iira_pkg::POS_W-1:0]    position,
    input  logic [iira_pkg::VALUE_W-1:0]  value,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [iira_pkg::VALUE_W-1:0]  read_value,
    output logic [iira_pkg::STAT_W-1:0]   status,
    output logic [iira_pkg::COUNT_W-1:0]  count,
    output logic                          is_empty
);

    localparam int CW  = $clog2(CAPACITY + 1);  // count width
    localparam int GS  = 8;                      // cells per read group
    localparam int NG  = (CAPACITY + GS - 1) / GS;
    localparam int PW  = iira_pkg::MAX_POS_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    // ---------------------------------------------------------------
    // Handshake and pipeline advance
    // ---------------------------------------------------------------
    logic p_valid_reg;      // stage 1: group partials held
    logic rsp_valid_reg;    // stage 2: response held
    logic adv;              // stage 1 moves into stage 2
    logic req_fire;

    assign adv       = p_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !p_valid_reg || adv;
    assign req_fire  = req_valid && req_ready;

    // ---------------------------------------------------------------
    // Request decode against the current count
    // ---------------------------------------------------------------
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [PW-1:0]         cnt_p;
    logic [PW-1:0]         pos_p;
    logic                  full;
    iira_pkg::cell_ctrl_t  ctrl;
    iira_pkg::status_t     st_d;
    logic                  rd_ok_d;
    logic [DATA_WIDTH-1:0] wr_data;

    assign cnt_p   = PW'(count_reg);
    assign pos_p   = PW'(position);
    assign full    = (cnt_p == CAP_P);
    assign wr_data = DATA_WIDTH'(value);

    always_comb
    begin
        ctrl.cmd   = iira_pkg::CMD_NONE;
        ctrl.pos   = pos_p;     // read select uses this too
        st_d       = iira_pkg::ST_OK;
        rd_ok_d    = 1'b0;
        count_next = count_reg;
        case (op)
            iira_pkg::OP_APPEND:
            begin
                ctrl.pos = cnt_p;
                if (full)
                    st_d = iira_pkg::ST_FULL;
                else
                begin
                    ctrl.cmd   = iira_pkg::CMD_WRITE;
                    count_next = count_reg + 1'b1;
                end
            end
            iira_pkg::OP_INSERT:
            begin
                // bad position wins over full
                if (pos_p > cnt_p)
                    st_d = iira_pkg::ST_RANGE;
                else if (full)
                    st_d = iira_pkg::ST_FULL;
                else
                begin
                    ctrl.cmd   = iira_pkg::CMD_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            iira_pkg::OP_REMOVE:
            begin
                if (pos_p >= cnt_p)
                    st_d = iira_pkg::ST_RANGE;
                else
                begin
                    ctrl.cmd   = iira_pkg::CMD_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
            iira_pkg::OP_READ:
            begin
                if (pos_p >= cnt_p)
                    st_d = iira_pkg::ST_RANGE;
                else
                    rd_ok_d = 1'b1;
            end
            iira_pkg::OP_WRITE:
            begin
                if (pos_p >= cnt_p)
                    st_d = iira_pkg::ST_RANGE;
                else
                    ctrl.cmd = iira_pkg::CMD_WRITE;
            end
            iira_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // unused codes: no effect, count reported unchanged
                count_next = count_reg;
            end
        endcase
        if (!req_fire)
            ctrl.cmd = iira_pkg::CMD_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (req_fire)
            count_reg <= count_next;
    end

    // ---------------------------------------------------------------
    // Chain of cells
    // ---------------------------------------------------------------
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_sel  [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        iira_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .wr_data    (wr_data),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // ---------------------------------------------------------------
    // Stage 1: per-group OR of the addressed entry, plus decoded result
    // ---------------------------------------------------------------
    logic [DATA_WIDTH-1:0]        grp_next [NG];
    logic [DATA_WIDTH-1:0]        grp_reg  [NG];
    iira_pkg::status_t            p_status_reg;
    logic [iira_pkg::COUNT_W-1:0] p_count_reg;
    logic                         p_empty_reg;
    logic                         p_rd_ok_reg;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GS; k++)
            begin
                if (g * GS + k < CAPACITY)
                    grp_next[g] = grp_next[g] | cell_sel[g * GS + k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (req_fire)
            p_valid_reg <= 1'b1;
        else if (adv)
            p_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            grp_reg      <= grp_next;
            p_status_reg <= st_d;
            p_count_reg  <= iira_pkg::COUNT_W'(count_next);
            p_empty_reg  <= (count_next == '0);
            p_rd_ok_reg  <= rd_ok_d;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: final OR and response register
    // ---------------------------------------------------------------
    logic [DATA_WIDTH-1:0]             rd_all;
    logic [iira_pkg::VALUE_W-1:0]      read_value_reg;
    iira_pkg::status_t                 status_reg;
    logic [iira_pkg::COUNT_W-1:0]      count_out_reg;
    logic                              is_empty_reg;

    always_comb
    begin
        rd_all = '0;
        for (int g = 0; g < NG; g++)
            rd_all = rd_all | grp_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            read_value_reg <= p_rd_ok_reg ? iira_pkg::VALUE_W'(rd_all) : '0;
            status_reg     <= p_status_reg;
            count_out_reg  <= p_count_reg;
            is_empty_reg   <= p_empty_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = count_out_reg;
    assign is_empty   = is_empty_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(count_reg) <= CAP_P)
        else $error("entry count beyond capacity");

    a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && op == iira_pkg::OP_APPEND && full)
        |=> (p_status_reg == iira_pkg::ST_FULL && $stable(count_reg)))
        else $error("append on full array not rejected");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != iira_pkg::ST_OK) |-> (read_value == '0))
        else $error("read data on failed request");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && rsp_valid && !rsp_ready) |-> !req_ready)
        else $error("request taken with pipeline full");

endmodule
